// ----- rtl/core/rads_pkg.sv -----
// ----------------------------------------------------------------------------
// rads_pkg
// Shared types and codes of the RC arm/disarm supervisor.
// ----------------------------------------------------------------------------
package rads_pkg;

   // event kinds carried in req_tuser
   localparam logic [2:0] EV_RC_FRAME = 3'd0;
   localparam logic [2:0] EV_HEALTH   = 3'd1;
   localparam logic [2:0] EV_ARMING   = 3'd2;
   localparam logic [2:0] EV_LANDED   = 3'd3;
   localparam logic [2:0] EV_ODOMETRY = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_MODE_REQ     = 2'd0;
   localparam logic [1:0] CSR_STICK_THRESH = 2'd1;
   localparam logic [1:0] CSR_ARM_HOLD     = 2'd2;
   localparam logic [1:0] CSR_DISARM_HOLD  = 2'd3;

   // configuration reset values
   localparam logic [11:0] MODE_REQ_RESET     = 12'd0;
   localparam logic [10:0] STICK_THRESH_RESET = 11'd41;
   localparam logic [15:0] ARM_HOLD_RESET     = 16'd1000;
   localparam logic [15:0] DISARM_HOLD_RESET  = 16'd1000;

   // arm request codes
   localparam logic [1:0] ARM_REQ_NONE   = 2'd0;
   localparam logic [1:0] ARM_REQ_ARM    = 2'd1;
   localparam logic [1:0] ARM_REQ_DISARM = 2'd2;

   // command kinds
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_IDLE  = 2'd1;
   localparam logic [1:0] CMD_PILOT = 2'd2;

   // accuracy code for a passed check
   localparam logic [1:0] ACC_PASSED = 2'd0;

   // status_seen bits
   localparam int SEEN_ODOM    = 0;
   localparam int SEEN_ARMING  = 1;
   localparam int SEEN_HEALTH  = 2;
   localparam int SEEN_LANDED  = 3;

   typedef enum logic [1:0] {
      STAGE_CHECK_PREREQ = 2'd0,
      STAGE_WAIT_ARMING  = 2'd1,
      STAGE_WAIT_ENABLE  = 2'd2,
      STAGE_RUNNING      = 2'd3
   } stage_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [31:0]       time_ms;
      logic signed [11:0] roll;
      logic signed [11:0] pitch;
      logic signed [11:0] yaw;
      logic signed [11:0] throttle;
      logic [2:0]        switch_bits;
      logic [1:0]        flight_mode;
      logic              status_flag;
      logic              radio_link_failed;
      logic [7:0]        accuracy_codes;
   } item_type;

   typedef struct packed {
      logic [11:0] mode_requirements;
      logic [10:0] stick_threshold;
      logic [15:0] arm_hold_ms;
      logic [15:0] disarm_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0] arm_request;
      logic [1:0] command_kind;
      logic       controller_reset;
      logic [1:0] active_mode;
      stage_type  stage;
   } result_type;

endpackage

// ----- rtl/core/rads_core.sv -----
// ----------------------------------------------------------------------------
// rads_core
// Supervisor state and the single-pass decision logic for one event.
// ----------------------------------------------------------------------------
module rads_core #(
   parameter int STICK_FULL_SCALE = 1024,
   parameter int NUM_FLIGHT_MODES = 3,
   parameter int TIME_WIDTH       = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  rads_pkg::item_type  item,
   input  rads_pkg::cfg_type   cfg,
   output rads_pkg::result_type result
);

   // stick compare width: holds sticks, band and full scale
   localparam int LOG_FS = $clog2(STICK_FULL_SCALE);
   localparam int CW     = (LOG_FS + 3 > 14) ? LOG_FS + 3 : 14;
   localparam logic signed [CW-1:0] FS_S = CW'(STICK_FULL_SCALE);

   // state registers
   rads_pkg::stage_type   stage_ff, stage_in;
   logic [1:0]            mode_ff, mode_in;
   logic [TIME_WIDTH-1:0] arm_start_ff, arm_start_in;
   logic [TIME_WIDTH-1:0] disarm_start_ff, disarm_start_in;
   logic [3:0]            seen_ff, seen_in;
   logic                  armed_ff, armed_in;
   logic                  landed_ff, landed_in;
   logic                  health_ok_ff, health_ok_in;
   logic [7:0]            acc_ff, acc_in;

   // timestamp truncated or extended to the time width
   logic [63:0]           time64, arm_hold64, disarm_hold64;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] arm_diff, disarm_diff;
   logic                  arm_held, disarm_held;

   assign time64        = {32'd0, item.time_ms};
   assign arm_hold64    = {48'd0, cfg.arm_hold_ms};
   assign disarm_hold64 = {48'd0, cfg.disarm_hold_ms};
   assign now           = time64[TIME_WIDTH-1:0];
   assign arm_diff      = now - arm_start_ff;
   assign disarm_diff   = now - disarm_start_ff;
   assign arm_held      = arm_diff > arm_hold64[TIME_WIDTH-1:0];
   assign disarm_held   = disarm_diff > disarm_hold64[TIME_WIDTH-1:0];

   // stick gesture comparisons
   logic [12:0]            abs_roll, abs_pitch, abs_rp;
   logic signed [CW-1:0]   band_s, yaw_s, thr_s;
   logic                   rp_centered, yaw_low, yaw_high, thr_low;

   always_comb begin
      abs_roll  = item.roll[11]  ? 13'(-{item.roll[11], item.roll})
                                 : {1'b0, item.roll};
      abs_pitch = item.pitch[11] ? 13'(-{item.pitch[11], item.pitch})
                                 : {1'b0, item.pitch};
      abs_rp    = (abs_roll > abs_pitch) ? abs_roll : abs_pitch;
   end

   assign band_s      = CW'({1'b0, cfg.stick_threshold});
   assign yaw_s       = CW'(item.yaw);
   assign thr_s       = CW'(item.throttle);
   assign rp_centered = abs_rp < {2'b00, cfg.stick_threshold};
   assign yaw_low     = yaw_s < (band_s - FS_S);
   assign yaw_high    = yaw_s > (FS_S - band_s);
   assign thr_low     = thr_s < (band_s - FS_S);

   // flight mode gating against stored accuracy codes
   logic [3:0] mode_req;
   logic [3:0] acc_fail;
   logic       mode_ok;

   always_comb begin
      case (item.flight_mode)
         2'd0:    mode_req = cfg.mode_requirements[3:0];
         2'd1:    mode_req = cfg.mode_requirements[7:4];
         2'd2:    mode_req = cfg.mode_requirements[11:8];
         default: mode_req = 4'd0;
      endcase
      for (int i = 0; i < 4; i++) begin
         acc_fail[i] = acc_ff[2*i +: 2] != rads_pkg::ACC_PASSED;
      end
      mode_ok = (32'(item.flight_mode) < NUM_FLIGHT_MODES) && ((mode_req & acc_fail) == 4'd0);
   end

   // switches
   logic frame_valid, enable_sw, kill_sw;
   assign frame_valid = item.switch_bits[0];
   assign enable_sw   = item.switch_bits[1];
   assign kill_sw     = item.switch_bits[2];

   // next state and result
   logic [1:0] req_code, cmd_code;
   logic       rst_flag;

   always_comb begin
      stage_in        = stage_ff;
      mode_in         = mode_ff;
      arm_start_in    = arm_start_ff;
      disarm_start_in = disarm_start_ff;
      seen_in         = seen_ff;
      armed_in        = armed_ff;
      landed_in       = landed_ff;
      health_ok_in    = health_ok_ff;
      acc_in          = acc_ff;
      req_code        = rads_pkg::ARM_REQ_NONE;
      cmd_code        = rads_pkg::CMD_NONE;
      rst_flag        = 1'b0;

      case (item.mode)
         rads_pkg::EV_HEALTH: begin
            health_ok_in                   = item.status_flag;
            acc_in                         = item.accuracy_codes;
            seen_in[rads_pkg::SEEN_HEALTH] = 1'b1;
            if (item.radio_link_failed) begin
               stage_in = rads_pkg::STAGE_CHECK_PREREQ;
            end
         end
         rads_pkg::EV_ARMING: begin
            armed_in                       = item.status_flag;
            seen_in[rads_pkg::SEEN_ARMING] = 1'b1;
         end
         rads_pkg::EV_LANDED: begin
            landed_in                      = item.status_flag;
            seen_in[rads_pkg::SEEN_LANDED] = 1'b1;
         end
         rads_pkg::EV_ODOMETRY: begin
            seen_in[rads_pkg::SEEN_ODOM] = 1'b1;
         end
         rads_pkg::EV_RC_FRAME: begin
            if (frame_valid) begin
               case (stage_ff)
                  rads_pkg::STAGE_CHECK_PREREQ: begin
                     if (seen_ff == 4'hF) begin
                        arm_start_in = now;
                        stage_in     = rads_pkg::STAGE_WAIT_ARMING;
                     end
                  end
                  rads_pkg::STAGE_WAIT_ARMING: begin
                     if (armed_ff) begin
                        stage_in = rads_pkg::STAGE_WAIT_ENABLE;
                     end else if (rp_centered && yaw_low && thr_low) begin
                        if (arm_held) begin
                           req_code     = rads_pkg::ARM_REQ_ARM;
                           arm_start_in = now;
                        end else if (!enable_sw || kill_sw || !health_ok_ff || !mode_ok) begin
                           arm_start_in = now;
                        end
                     end else begin
                        arm_start_in = now;
                     end
                  end
                  rads_pkg::STAGE_WAIT_ENABLE: begin
                     if (!armed_ff) begin
                        arm_start_in = now;
                        stage_in     = rads_pkg::STAGE_CHECK_PREREQ;
                     end else if (enable_sw && !kill_sw && mode_ok) begin
                        rst_flag        = 1'b1;
                        mode_in         = item.flight_mode;
                        disarm_start_in = now;
                        stage_in        = rads_pkg::STAGE_RUNNING;
                     end
                  end
                  default: begin
                     if (!armed_ff) begin
                        arm_start_in = now;
                        stage_in     = rads_pkg::STAGE_CHECK_PREREQ;
                     end else if (kill_sw) begin
                        req_code = rads_pkg::ARM_REQ_DISARM;
                     end else if (!enable_sw) begin
                        stage_in = rads_pkg::STAGE_WAIT_ENABLE;
                     end else begin
                        if (item.flight_mode != mode_ff && mode_ok) begin
                           rst_flag = 1'b1;
                           mode_in  = item.flight_mode;
                        end
                        if (landed_ff && thr_low) begin
                           cmd_code = rads_pkg::CMD_IDLE;
                           if (rp_centered && yaw_high) begin
                              // disarm gesture: timer keeps running while held
                              if (disarm_held) begin
                                 req_code        = rads_pkg::ARM_REQ_DISARM;
                                 disarm_start_in = now;
                              end
                           end else begin
                              disarm_start_in = now;
                           end
                        end else begin
                           cmd_code        = rads_pkg::CMD_PILOT;
                           disarm_start_in = now;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      result.arm_request      = req_code;
      result.command_kind     = cmd_code;
      result.controller_reset = rst_flag;
      result.active_mode      = mode_in;
      result.stage            = stage_in;
   end

   // state update on each processed event
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff        <= rads_pkg::STAGE_CHECK_PREREQ;
         mode_ff         <= 2'd0;
         arm_start_ff    <= '0;
         disarm_start_ff <= '0;
         seen_ff         <= 4'd0;
         armed_ff        <= 1'b0;
         landed_ff       <= 1'b0;
         health_ok_ff    <= 1'b0;
         acc_ff          <= 8'hFF;
      end else if (fire) begin
         stage_ff        <= stage_in;
         mode_ff         <= mode_in;
         arm_start_ff    <= arm_start_in;
         disarm_start_ff <= disarm_start_in;
         seen_ff         <= seen_in;
         armed_ff        <= armed_in;
         landed_ff       <= landed_in;
         health_ok_ff    <= health_ok_in;
         acc_ff          <= acc_in;
      end
   end

endmodule

// ----- rtl/core/rc_arm_disarm_supervisor_unit.sv -----
// ----------------------------------------------------------------------------
// rc_arm_disarm_supervisor_unit
// RC stick-gesture arm/disarm supervisor: one result per event.
// ----------------------------------------------------------------------------
// rsp_tvalid rises once an accepted event has passed the input register and then the result register.
// Throughput: one event per cycle while rsp_tready holds; the supervisor state updates in one pass.
// The input register refills while a result waits, so a stalled rsp side
// holds at most one event in each register.
// Reset: synchronous, active high; stage 0, flags cleared, accuracy unknown,
// configuration registers at their defaults.
module rc_arm_disarm_supervisor_unit #(
   parameter int STICK_FULL_SCALE = 1024,
   parameter int NUM_FLIGHT_MODES = 3,
   parameter int TIME_WIDTH       = 32
) (
   input  logic        clock,
   input  logic        reset,
   // event stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // time_ms[31:0], roll[43:32], pitch[55:44], yaw[67:56], throttle[79:68],
   // switch_bits[82:80], flight_mode[84:83], status_flag[85],
   // radio_link_failed[86], accuracy_codes[94:87], zero[95]
   input  logic [95:0] req_tdata,
   // mode[2:0]
   input  logic [2:0]  req_tuser,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // arm_request[1:0], command_kind[3:2], controller_reset[4],
   // active_mode[6:5], stage[8:7], zero[15:9]
   output logic [15:0] rsp_tdata,
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   rads_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_requirements <= rads_pkg::MODE_REQ_RESET;
         cfg_ff.stick_threshold   <= rads_pkg::STICK_THRESH_RESET;
         cfg_ff.arm_hold_ms       <= rads_pkg::ARM_HOLD_RESET;
         cfg_ff.disarm_hold_ms    <= rads_pkg::DISARM_HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rads_pkg::CSR_MODE_REQ:     cfg_ff.mode_requirements <= csr_wdata[11:0];
            rads_pkg::CSR_STICK_THRESH: cfg_ff.stick_threshold   <= csr_wdata[10:0];
            rads_pkg::CSR_ARM_HOLD:     cfg_ff.arm_hold_ms       <= csr_wdata;
            rads_pkg::CSR_DISARM_HOLD:  cfg_ff.disarm_hold_ms    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // handshake control
   logic in_v_ff, out_v_ff;
   logic advance;

   assign advance    = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || advance;
   assign rsp_tvalid = out_v_ff;

   // input register
   rads_pkg::item_type item_ff, item_in;

   always_comb begin
      item_in.mode              = req_tuser;
      item_in.time_ms           = req_tdata[31:0];
      item_in.roll              = req_tdata[43:32];
      item_in.pitch             = req_tdata[55:44];
      item_in.yaw               = req_tdata[67:56];
      item_in.throttle          = req_tdata[79:68];
      item_in.switch_bits       = req_tdata[82:80];
      item_in.flight_mode       = req_tdata[84:83];
      item_in.status_flag       = req_tdata[85];
      item_in.radio_link_failed = req_tdata[86];
      item_in.accuracy_codes    = req_tdata[94:87];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_tready) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   // supervisor decision
   rads_pkg::result_type result_in, result_ff;

   rads_core #(
      .STICK_FULL_SCALE (STICK_FULL_SCALE),
      .NUM_FLIGHT_MODES (NUM_FLIGHT_MODES),
      .TIME_WIDTH       (TIME_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= advance || (out_v_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tdata = {7'd0, result_ff.stage, result_ff.active_mode,
                       result_ff.controller_reset, result_ff.command_kind,
                       result_ff.arm_request};

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rc_arm_disarm_supervisor_unit. A short scripted
// sequence walks the supervisor through prerequisites, arming, enable,
// running, disarm, kill and link loss. Random phases under changing
// register settings follow. Every result transaction is compared field by
// field against a scripted expectation or an in-bench model of the supervisor.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rads_pkg::*;

   localparam int FULL_SCALE     = 1024;
   localparam int FLIGHT_MODES   = 3;
   localparam int PHASES         = 8;
   localparam int PHASE_EVENTS   = 45;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 4;
   // event kinds with no meaning; the block must ignore them
   localparam logic [2:0] EV_SPARE_LO = 3'd5;
   localparam logic [2:0] EV_SPARE_HI = 3'd7;
   localparam logic [31:0] WRAP_T0    = 32'hFFFF_FF00;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // time_ms, roll, pitch, yaw, throttle, switch_bits, flight_mode,
   // status_flag, radio_link_failed, accuracy_codes, zero pad
   logic [95:0] req_tdata   = '0;
   // mode
   logic [2:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // arm_request, command_kind, controller_reset, active_mode, stage, zero pad
   logic [15:0] rsp_tdata;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_index   = '0;
   logic [15:0] csr_wdata   = '0;

   rc_arm_disarm_supervisor_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // supervisor model state
   stage_type   sup_stage;
   logic [1:0]  sup_mode;
   logic [31:0] arm_t0;
   logic [31:0] disarm_t0;
   logic [3:0]  seen;
   logic        armed_q;
   logic        landed_q;
   logic        health_q;
   logic [7:0]  acc_q;
   cfg_type     cfg;

   logic [31:0] clock_ms;
   result_type  awaited_outcomes[$];
   int          mismatches  = 0;
   int          cycle_count = 0;
   int          stall_left  = 0;
   bit          idling      = 1'b1;

   typedef struct {
      item_type   ev;
      bit         typed;
      result_type want;
   } script_row;

   // estimator gate: every required item must report passed
   function automatic logic mode_allowed(logic [1:0] m);
      logic [3:0] need;
      if (m >= FLIGHT_MODES) return 1'b0;
      need = cfg.mode_requirements[4*m +: 4];
      for (int i = 0; i < 4; i++)
         if (need[i] && acc_q[2*i +: 2] != ACC_PASSED) return 1'b0;
      return 1'b1;
   endfunction

   // one event through the supervisor; returns the result it causes
   function automatic result_type supervise_event(item_type ev);
      result_type  r;
      int          band, roll, pitch, yaw, thr, rp;
      logic        thr_low, enable, kill;
      logic [31:0] now;
      r = '0;
      r.arm_request  = ARM_REQ_NONE;
      r.command_kind = CMD_NONE;
      band    = int'(cfg.stick_threshold);
      roll    = $signed(ev.roll);
      pitch   = $signed(ev.pitch);
      yaw     = $signed(ev.yaw);
      thr     = $signed(ev.throttle);
      roll    = (roll < 0) ? -roll : roll;
      pitch   = (pitch < 0) ? -pitch : pitch;
      rp      = (roll > pitch) ? roll : pitch;
      thr_low = thr < -FULL_SCALE + band;
      enable  = ev.switch_bits[1];
      kill    = ev.switch_bits[2];
      now     = ev.time_ms;
      case (ev.mode)
         EV_HEALTH: begin
            health_q = ev.status_flag;
            acc_q    = ev.accuracy_codes;
            seen[SEEN_HEALTH] = 1'b1;
            if (ev.radio_link_failed) sup_stage = STAGE_CHECK_PREREQ;
         end
         EV_ARMING: begin
            armed_q = ev.status_flag;
            seen[SEEN_ARMING] = 1'b1;
         end
         EV_LANDED: begin
            landed_q = ev.status_flag;
            seen[SEEN_LANDED] = 1'b1;
         end
         EV_ODOMETRY: seen[SEEN_ODOM] = 1'b1;
         EV_RC_FRAME: if (ev.switch_bits[0]) begin
            case (sup_stage)
               STAGE_CHECK_PREREQ: if (seen == 4'hF) begin
                  arm_t0    = now;
                  sup_stage = STAGE_WAIT_ARMING;
               end
               STAGE_WAIT_ARMING: begin
                  if (armed_q) begin
                     sup_stage = STAGE_WAIT_ENABLE;
                  end else if (rp < band && yaw < -FULL_SCALE + band && thr_low) begin
                     if ((now - arm_t0) > 32'(cfg.arm_hold_ms)) begin
                        r.arm_request = ARM_REQ_ARM;
                        arm_t0        = now;
                     end else if (!enable || kill || !health_q || !mode_allowed(ev.flight_mode)) begin
                        arm_t0 = now;
                     end
                  end else begin
                     arm_t0 = now;
                  end
               end
               STAGE_WAIT_ENABLE: begin
                  if (!armed_q) begin
                     arm_t0    = now;
                     sup_stage = STAGE_CHECK_PREREQ;
                  end else if (enable && !kill && mode_allowed(ev.flight_mode)) begin
                     r.controller_reset = 1'b1;
                     sup_mode  = ev.flight_mode;
                     disarm_t0 = now;
                     sup_stage = STAGE_RUNNING;
                  end
               end
               STAGE_RUNNING: begin
                  if (!armed_q) begin
                     arm_t0    = now;
                     sup_stage = STAGE_CHECK_PREREQ;
                  end else if (kill) begin
                     r.arm_request = ARM_REQ_DISARM;
                  end else if (!enable) begin
                     sup_stage = STAGE_WAIT_ENABLE;
                  end else begin
                     if (ev.flight_mode != sup_mode && mode_allowed(ev.flight_mode)) begin
                        r.controller_reset = 1'b1;
                        sup_mode = ev.flight_mode;
                     end
                     if (landed_q && thr_low) begin
                        r.command_kind = CMD_IDLE;
                        // disarm gesture keeps its start time while held
                        if (rp < band && yaw > FULL_SCALE - band) begin
                           if ((now - disarm_t0) > 32'(cfg.disarm_hold_ms)) begin
                              r.arm_request = ARM_REQ_DISARM;
                              disarm_t0     = now;
                           end
                        end else begin
                           disarm_t0 = now;
                        end
                     end else begin
                        r.command_kind = CMD_PILOT;
                        disarm_t0      = now;
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase
      r.active_mode = sup_mode;
      r.stage       = sup_stage;
      return r;
   endfunction

   function automatic item_type mk_item(logic [2:0] kind, logic [31:0] t, int roll, int pitch,
                                        int yaw, int thr, logic [2:0] sw, logic [1:0] fm,
                                        logic flag, logic link, logic [7:0] acc);
      item_type e;
      e.mode              = kind;
      e.time_ms           = t;
      e.roll              = 12'(roll);
      e.pitch             = 12'(pitch);
      e.yaw               = 12'(yaw);
      e.throttle          = 12'(thr);
      e.switch_bits       = sw;
      e.flight_mode       = fm;
      e.status_flag       = flag;
      e.radio_link_failed = link;
      e.accuracy_codes    = acc;
      return e;
   endfunction

   function automatic result_type outcome(logic [1:0] req, logic [1:0] cmd, logic rst,
                                          logic [1:0] m, stage_type st);
      result_type r;
      r.arm_request      = req;
      r.command_kind     = cmd;
      r.controller_reset = rst;
      r.active_mode      = m;
      r.stage            = st;
      return r;
   endfunction

   // stick value around a center, clipped to full scale
   function automatic int stick_near(int center, int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > FULL_SCALE) v = FULL_SCALE;
      if (v < -FULL_SCALE) v = -FULL_SCALE;
      return v;
   endfunction

   // accuracy codes biased toward passed
   function automatic logic [7:0] rand_acc();
      logic [7:0] a;
      a = 8'($urandom()) & 8'($urandom());
      if ($urandom_range(0, 1)) a = {4{ACC_PASSED}};
      return a;
   endfunction

   // next random event, steered by the current supervisor stage
   function automatic item_type make_event();
      item_type e;
      int       b, pick;
      b    = int'(cfg.stick_threshold);
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 15))
         0:          ;
         1, 2, 3:    clock_ms += $urandom_range(1, 50);
         15:         clock_ms = $urandom();
         12, 13, 14: clock_ms += $urandom_range(0, 32'(cfg.disarm_hold_ms) / 2 + 100);
         default:    clock_ms += $urandom_range(0, 32'(cfg.arm_hold_ms) / 3 + 20);
      endcase
      // land right on the hold boundary now and then
      if ($urandom_range(0, 7) == 0) begin
         if (sup_stage == STAGE_WAIT_ARMING)
            clock_ms = arm_t0 + cfg.arm_hold_ms + $urandom_range(0, 1);
         else if (sup_stage == STAGE_RUNNING)
            clock_ms = disarm_t0 + cfg.disarm_hold_ms + $urandom_range(0, 1);
      end
      e = mk_item(EV_RC_FRAME, clock_ms, stick_near(0, FULL_SCALE), stick_near(0, FULL_SCALE),
                  stick_near(0, FULL_SCALE), stick_near(0, FULL_SCALE), 3'b011,
                  $urandom_range(0, 1) ? sup_mode : 2'($urandom_range(0, 2)),
                  1'($urandom_range(0, 1)), 1'b0, rand_acc());
      if ($urandom_range(0, 11) == 0) e.switch_bits[2] = 1'b1;
      if ($urandom_range(0, 9) == 0) e.switch_bits[1] = 1'b0;
      if ($urandom_range(0, 19) == 0) e.switch_bits[0] = 1'b0;
      if ($urandom_range(0, 11) == 0) e.flight_mode = 2'd3;

      if (pick < 8) begin
         // noise: any kind, any field
         e = mk_item(3'($urandom_range(0, 7)), $urandom(), stick_near(0, FULL_SCALE),
                     stick_near(0, FULL_SCALE), stick_near(0, FULL_SCALE),
                     stick_near(0, FULL_SCALE), 3'($urandom()), 2'($urandom()),
                     1'($urandom()), 1'($urandom()), 8'($urandom()));
      end else if ((seen != 4'hF && pick < 80) || pick < 28) begin
         e.mode = 3'($urandom_range(EV_HEALTH, EV_ODOMETRY));
         case (e.mode)
            EV_HEALTH: begin
               e.status_flag       = ($urandom_range(0, 6) != 0);
               e.radio_link_failed = ($urandom_range(0, 14) == 0);
            end
            EV_ARMING: e.status_flag = ($urandom_range(0, 9) < 8);
            default:   ;
         endcase
      end else if (sup_stage == STAGE_WAIT_ARMING && pick < 85) begin
         e.roll     = 12'(stick_near(0, b));
         e.pitch    = 12'(stick_near(0, b));
         e.yaw      = 12'(stick_near(-FULL_SCALE, b));
         e.throttle = 12'(stick_near(-FULL_SCALE, b));
      end else if (sup_stage == STAGE_RUNNING && pick < 75) begin
         e.throttle = 12'(stick_near(-FULL_SCALE, b));
         if (pick < 60) begin
            e.roll  = 12'(stick_near(0, b));
            e.pitch = 12'(stick_near(0, b));
            e.yaw   = 12'(stick_near(FULL_SCALE, b));
         end
      end
      return e;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // present one event and hold it until the transaction completes
   task automatic send_event(input item_type e, output result_type predicted);
      req_tvalid <= 1'b1;
      req_tuser  <= e.mode;
      req_tdata  <= {1'b0, e.accuracy_codes, e.radio_link_failed, e.status_flag,
                     e.flight_mode, e.switch_bits, e.throttle, e.yaw, e.pitch, e.roll,
                     e.time_ms};
      do @(posedge clock); while (!req_tready);
      predicted = supervise_event(e);
   endtask

   // random sender gap
   task automatic maybe_pause();
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // stop sending until every awaited result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_MODE_REQ;
      csr_wdata <= 16'(c.mode_requirements);
      @(posedge clock);
      csr_index <= CSR_STICK_THRESH;
      csr_wdata <= 16'(c.stick_threshold);
      @(posedge clock);
      csr_index <= CSR_ARM_HOLD;
      csr_wdata <= c.arm_hold_ms;
      @(posedge clock);
      csr_index <= CSR_DISARM_HOLD;
      csr_wdata <= c.disarm_hold_ms;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg = c;
   endtask

   // result side: random stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = awaited_outcomes.pop_front();
            check_field("arm_request", want.arm_request, rsp_tdata[1:0]);
            check_field("command_kind", want.command_kind, rsp_tdata[3:2]);
            check_field("controller_reset", want.controller_reset, rsp_tdata[4]);
            check_field("active_mode", want.active_mode, rsp_tdata[6:5]);
            check_field("stage", want.stage, rsp_tdata[8:7]);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      script_row  script[25];
      item_type   e;
      result_type predicted;
      cfg_type    plan;
      int         counted;

      sup_stage = STAGE_CHECK_PREREQ;
      sup_mode  = '0;
      arm_t0    = '0;
      disarm_t0 = '0;
      seen      = '0;
      armed_q   = 1'b0;
      landed_q  = 1'b0;
      health_q  = 1'b0;
      acc_q     = 8'hFF;
      cfg       = '{MODE_REQ_RESET, STICK_THRESH_RESET, ARM_HOLD_RESET, DISARM_HOLD_RESET};

      // scripted walk through every stage under the reset configuration
      script[0]  = '{mk_item(EV_RC_FRAME, 32'd0, 0, 0, 0, -1024, 3'b001, 2'd0, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      script[1]  = '{mk_item(EV_SPARE_HI, 32'hFFFF_FFFF, -1024, -1024, -1024, -1024, 3'b111,
                             2'd3, 1, 1, 8'hFF),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      script[2]  = '{mk_item(EV_SPARE_LO, 32'd0, 1024, 1024, 1024, 1024, 3'b000, 2'd0, 0, 0,
                             8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      script[3]  = '{mk_item(EV_ODOMETRY, 32'd0, 0, 0, 0, 0, 3'b000, 2'd0, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      script[4]  = '{mk_item(EV_ARMING, 32'd0, 0, 0, 0, 0, 3'b000, 2'd0, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      script[5]  = '{mk_item(EV_HEALTH, 32'd0, 0, 0, 0, 0, 3'b000, 2'd0, 1, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      script[6]  = '{mk_item(EV_LANDED, 32'd0, 0, 0, 0, 0, 3'b000, 2'd0, 1, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      // invalid frame is ignored even with every status seen
      script[7]  = '{mk_item(EV_RC_FRAME, WRAP_T0, 0, 0, 0, -1024, 3'b110, 2'd0, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_CHECK_PREREQ)};
      script[8]  = '{mk_item(EV_RC_FRAME, WRAP_T0, 0, 0, 0, -1024, 3'b001, 2'd0, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_WAIT_ARMING)};
      // arm gesture held across the timestamp wrap
      script[9]  = '{mk_item(EV_RC_FRAME, WRAP_T0 + 32'd400, 0, 0, -1024, -1024, 3'b011, 2'd0,
                             0, 0, 8'h00), 1'b0, '0};
      script[10] = '{mk_item(EV_RC_FRAME, WRAP_T0 + 32'd1001, 0, 0, -1024, -1024, 3'b011, 2'd0,
                             0, 0, 8'h00), 1'b0, '0};
      script[11] = '{mk_item(EV_ARMING, 32'h300, 0, 0, 0, 0, 3'b000, 2'd0, 1, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_WAIT_ARMING)};
      script[12] = '{mk_item(EV_RC_FRAME, 32'h300, 0, 0, 0, -1024, 3'b001, 2'd0, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_WAIT_ENABLE)};
      // kill holds off the enable step
      script[13] = '{mk_item(EV_RC_FRAME, 32'h300, 0, 0, 0, -1024, 3'b111, 2'd2, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_WAIT_ENABLE)};
      // flight mode out of range is never allowed
      script[14] = '{mk_item(EV_RC_FRAME, 32'h300, 0, 0, 0, -1024, 3'b011, 2'd3, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd0, STAGE_WAIT_ENABLE)};
      script[15] = '{mk_item(EV_RC_FRAME, 32'h400, 0, 0, 0, -1024, 3'b011, 2'd2, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 1, 2'd2, STAGE_RUNNING)};
      script[16] = '{mk_item(EV_RC_FRAME, 32'h500, 0, 0, 0, 1024, 3'b011, 2'd1, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_PILOT, 1, 2'd1, STAGE_RUNNING)};
      // disarm gesture while landed at low throttle
      script[17] = '{mk_item(EV_RC_FRAME, 32'h600, 0, 0, 1024, -1024, 3'b011, 2'd1, 0, 0,
                             8'h00), 1'b0, '0};
      script[18] = '{mk_item(EV_RC_FRAME, 32'h8E9, 0, 0, 1024, -1024, 3'b011, 2'd1, 0, 0,
                             8'h00), 1'b0, '0};
      script[19] = '{mk_item(EV_RC_FRAME, 32'h900, 0, 0, 0, 0, 3'b111, 2'd1, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_DISARM, CMD_NONE, 0, 2'd1, STAGE_RUNNING)};
      script[20] = '{mk_item(EV_RC_FRAME, 32'h900, 0, 0, 0, 0, 3'b001, 2'd1, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd1, STAGE_WAIT_ENABLE)};
      // radio link loss restarts the sequence
      script[21] = '{mk_item(EV_HEALTH, 32'h900, 0, 0, 0, 0, 3'b000, 2'd0, 1, 1, 8'hFF),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd1, STAGE_CHECK_PREREQ)};
      script[22] = '{mk_item(EV_HEALTH, 32'h900, 0, 0, 0, 0, 3'b000, 2'd0, 1, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd1, STAGE_CHECK_PREREQ)};
      script[23] = '{mk_item(EV_ARMING, 32'h900, 0, 0, 0, 0, 3'b000, 2'd0, 0, 0, 8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd1, STAGE_CHECK_PREREQ)};
      script[24] = '{mk_item(EV_RC_FRAME, 32'h1000, -1024, 1024, 0, 0, 3'b001, 2'd0, 0, 0,
                             8'h00),
                     1'b1, outcome(ARM_REQ_NONE, CMD_NONE, 0, 2'd1, STAGE_WAIT_ARMING)};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         maybe_pause();
         send_event(script[i].ev, predicted);
         awaited_outcomes.push_back(script[i].typed ? script[i].want : predicted);
      end

      // random phases, each under its own register setting
      clock_ms = 32'hFFFF_0000;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: plan = '{12'h000, 11'd41, 16'd300, 16'd200};
            1: plan = '{12'hFFF, 11'd1024, 16'd0, 16'd0};
            2: plan = '{12'($urandom()), 11'd0, 16'hFFFF, 16'hFFFF};
            3: plan = '{12'($urandom()), 11'd1, 16'd1, 16'hFFFF};
            default: plan = '{12'($urandom()), 11'($urandom_range(10, 200)),
                              16'($urandom_range(0, 2500)), 16'($urandom_range(0, 2500))};
         endcase
         write_config(plan);
         idling  = (ph != PHASES - 1);
         counted = 0;
         while (counted < PHASE_EVENTS) begin
            e = make_event();
            if (e.mode <= EV_ODOMETRY && !(e.mode == EV_RC_FRAME && !e.switch_bits[0]))
               counted++;
            maybe_pause();
            if (idling && $urandom_range(0, 59) == 0) drain();
            send_event(e, predicted);
            awaited_outcomes.push_back(predicted);
         end
      end

      req_tvalid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/rads_pkg.sv
rtl/core/rads_core.sv
rtl/core/rc_arm_disarm_supervisor_unit.sv
tb/sv/tb.sv
